// ===== design/hbr_pkg.sv =====
// Package for the H-bridge register map and PWM unit.
// Holds the word types, register codes, sizing constants and sequencer states.
// No dependencies.
package hbr_pkg;

  // Averaging setup
  localparam int FRAMES_AVERAGED = 20;
  localparam int CHANNELS        = 2;
  localparam int SAMPLES_TOTAL   = FRAMES_AVERAGED * CHANNELS;
  localparam int ADC_MAX         = 4095;
  localparam int SUM_W           = $clog2(FRAMES_AVERAGED * ADC_MAX + 1);
  localparam int IDX_W           = $clog2(SAMPLES_TOTAL + 1);
  localparam int CHAN_W          = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

  // Shared divider sizing: 30-bit dividend, 16-bit divisor
  localparam int DIV_W     = 30;
  localparam int DEN_W     = 16;
  localparam int DIV_CNT_W = $clog2(DIV_W);

  // Arithmetic constants
  localparam logic [DIV_W-1:0] TICK_RATE     = DIV_W'(1000000);
  localparam logic [15:0]      MIN_FREQ      = 16'd100;
  localparam logic [15:0]      RESET_FREQ    = 16'd1000;
  localparam logic [13:0]      RESET_RELOAD  = 14'd1000;
  localparam logic [DEN_W-1:0] DEN_BYTE      = DEN_W'(255);
  localparam logic [DEN_W-1:0] DEN_WORD      = DEN_W'(65535);
  localparam logic [DEN_W-1:0] DEN_ADC       = DEN_W'(ADC_MAX);
  localparam logic [DEN_W-1:0] DEN_FRAMES    = DEN_W'(FRAMES_AVERAGED);
  localparam logic [7:0]       BASE_BUS_ADDR = 8'h20;
  localparam logic [7:0]       VERSION_CODE  = 8'd2;

  // Direction codes
  localparam logic [7:0] DIR_OFF  = 8'd0;
  localparam logic [7:0] DIR_FWD  = 8'd1;
  localparam logic [7:0] DIR_REV  = 8'd2;

  // Register addresses
  localparam logic [7:0] REG_DIR      = 8'h00;
  localparam logic [7:0] REG_SPEED8   = 8'h01;
  localparam logic [7:0] REG_SPEED_LO = 8'h02;
  localparam logic [7:0] REG_SPEED_HI = 8'h03;
  localparam logic [7:0] REG_FREQ_LO  = 8'h04;
  localparam logic [7:0] REG_FREQ_HI  = 8'h05;
  localparam logic [7:0] REG_AVG8     = 8'h10;
  localparam logic [7:0] REG_AVG_LO   = 8'h20;
  localparam logic [7:0] REG_AVG_HI   = 8'h21;
  localparam logic [7:0] REG_VERSION  = 8'hFE;
  localparam logic [7:0] REG_OWN_ADDR = 8'hFF;

  localparam int         NUM_WREGS    = 6;
  localparam logic [2:0] MAX_WBYTES   = 3'd6;

  // Request kinds
  localparam logic REQ_BUS    = 1'b0;
  localparam logic REQ_SAMPLE = 1'b1;

  typedef struct packed {
    logic        req_type;
    logic [7:0]  reg_addr;
    logic [2:0]  byte_count;
    logic [7:0]  data_0;
    logic [7:0]  data_1;
    logic [7:0]  data_2;
    logic [7:0]  data_3;
    logic [7:0]  data_4;
    logic [7:0]  data_5;
    logic [11:0] adc_sample;
  } in_word_t;

  typedef struct packed {
    logic [13:0] reload_value;
    logic [13:0] duty_fwd;
    logic [13:0] duty_rev;
    logic [1:0]  read_len;
    logic [7:0]  read_byte_0;
    logic [7:0]  read_byte_1;
  } out_word_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_RELOAD,
    ST_MUL_CMP,
    ST_DIV_CMP,
    ST_DIV_AVG,
    ST_MUL_AVG8,
    ST_DIV_AVG8,
    ST_FINISH
  } state_t;

endpackage

// ===== design/hbridge_register_map_pwm_unit.sv =====
// H-bridge register map with PWM reload/compare generation and ADC averaging.
// Depends on hbr_pkg for word types, register codes and sequencer states.
// One 30-step restoring divider and one 16x14 multiplier are shared by all math.

// Usage: each accepted word (bus transaction or ADC sample) yields one result
// word. Input stall is high while a word is being worked on. A read, an ignored
// write or a sample that does not close a frame goes straight to the finish
// state and then to the output register. A write that reaches registers 0..5
// runs the divider once for the reload value when direction is stop or unknown,
// and again for the compare value when forward or reverse. A sample that closes
// a 20-frame average runs it twice. The shared divider resolves one quotient bit
// per cycle over 30 bits and is run at most twice per word. A finished result
// waits in the output register, and the next word can be taken while it waits.
module hbridge_register_map_pwm_unit (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_we,
  input  logic [3:0]         cfg_data,
  input  logic               in_valid,
  output logic               in_stall,
  input  hbr_pkg::in_word_t  in_word,
  output logic               out_valid,
  input  logic               out_stall,
  output hbr_pkg::out_word_t out_word
);
  import hbr_pkg::*;

  // Sequencer
  state_t state;
  state_t state_next;

  // Register file and averaging state
  logic [3:0]        addr_offset;
  logic [7:0]        dir_reg;
  logic              speed_wide_mode;
  logic [7:0]        speed_byte;
  logic [15:0]       speed_word;
  logic [15:0]       freq_reg;
  logic [13:0]       reload_reg;
  logic [13:0]       cmp_fwd;
  logic [13:0]       cmp_rev;
  logic [IDX_W-1:0]  sample_index;
  logic [CHAN_W-1:0] chan_phase;
  logic [SUM_W-1:0]  chan0_sum;
  logic [11:0]       chan0_avg;
  logic [7:0]        chan0_avg8;

  // Pending read response
  logic [1:0] rd_len;
  logic [7:0] rd_b0;
  logic [7:0] rd_b1;

  // Shared divider
  logic [DIV_W-1:0]     div_dvd;
  logic [DEN_W-1:0]     div_den;
  logic [DEN_W-1:0]     div_rem;
  logic [DIV_CNT_W-1:0] div_cnt;
  logic [DEN_W:0]       div_rem_sh;
  logic                 div_ge;
  logic [DEN_W:0]       div_rem_sub;
  logic [DIV_W-1:0]     div_quot;
  logic                 div_last;
  logic                 div_run;

  // Shared multiplier
  logic [15:0]      mul_a;
  logic [13:0]      mul_b;
  logic [DIV_W-1:0] mul_p;

  // Control
  logic accept;
  logic load_out;

  // Decode of the incoming word
  logic             is_sample;
  logic             is_read;
  logic             is_write;
  logic [7:0]       din [NUM_WREGS];
  logic [7:0]       wbuf [NUM_WREGS];
  logic [NUM_WREGS-1:0] whit;
  logic [15:0]      freq_wr;
  logic [15:0]      freq_new;
  logic             chan0_hit;
  logic [SUM_W-1:0] sum_add;
  logic [IDX_W-1:0] idx_inc;
  logic             frame_done;
  logic [15:0]      rd_val;
  logic [1:0]       rd_n;

  assign accept = in_valid && !in_stall;

  // Output control: stall and divider run from state, output load also from the output handshake
  always_comb begin
    in_stall = (state != ST_IDLE);
    div_run  = (state == ST_RELOAD) || (state == ST_DIV_CMP) ||
               (state == ST_DIV_AVG) || (state == ST_DIV_AVG8);
    load_out = (state == ST_FINISH) && (!out_valid || !out_stall);
  end

  // Input decode
  always_comb begin
    din[0] = in_word.data_0;
    din[1] = in_word.data_1;
    din[2] = in_word.data_2;
    din[3] = in_word.data_3;
    din[4] = in_word.data_4;
    din[5] = in_word.data_5;
  end

  assign is_sample = (in_word.req_type == REQ_SAMPLE);
  assign is_read   = !is_sample && (in_word.byte_count == 3'd0);
  assign is_write  = !is_sample && (in_word.byte_count != 3'd0) &&
                     (in_word.byte_count <= MAX_WBYTES) && (in_word.reg_addr <= REG_FREQ_HI);

  // Which of registers 0..5 receive a byte, and which byte
  always_comb begin
    logic [7:0] off;
    for (int r = 0; r < NUM_WREGS; r++) begin
      off     = 8'(r) - in_word.reg_addr;
      whit[r] = (in_word.reg_addr <= 8'(r)) && (off < {5'd0, in_word.byte_count});
      wbuf[r] = din[off[2:0]];
    end
  end

  assign freq_wr  = {wbuf[5], wbuf[4]};
  assign freq_new = (whit[4] && whit[5]) ? ((freq_wr < MIN_FREQ) ? MIN_FREQ : freq_wr)
                                         : freq_reg;

  // Channel-0 accumulation
  assign chan0_hit  = (chan_phase == '0);
  assign sum_add    = chan0_hit ? (chan0_sum + SUM_W'(in_word.adc_sample)) : chan0_sum;
  assign idx_inc    = sample_index + IDX_W'(1);
  assign frame_done = (idx_inc == IDX_W'(SAMPLES_TOTAL));

  // Read map
  always_comb begin
    rd_val = 16'd0;
    rd_n   = 2'd0;
    case (in_word.reg_addr)
      REG_DIR: begin
        rd_val = {8'd0, dir_reg};
        rd_n   = 2'd1;
      end
      REG_SPEED8: begin
        rd_val = {8'd0, speed_byte};
        rd_n   = 2'd1;
      end
      REG_SPEED_LO, REG_SPEED_HI: begin
        rd_val = speed_word;
        rd_n   = 2'd2;
      end
      REG_FREQ_LO, REG_FREQ_HI: begin
        rd_val = freq_reg;
        rd_n   = 2'd2;
      end
      REG_AVG8: begin
        rd_val = {8'd0, chan0_avg8};
        rd_n   = 2'd1;
      end
      REG_AVG_LO, REG_AVG_HI: begin
        rd_val = {4'd0, chan0_avg};
        rd_n   = 2'd2;
      end
      REG_VERSION: begin
        rd_val = {8'd0, VERSION_CODE};
        rd_n   = 2'd1;
      end
      REG_OWN_ADDR: begin
        rd_val = {8'd0, BASE_BUS_ADDR + {4'd0, addr_offset}};
        rd_n   = 2'd1;
      end
      default: begin
        rd_val = 16'd0;
        rd_n   = 2'd0;
      end
    endcase
  end

  // Divider step: one quotient bit per cycle
  assign div_rem_sh  = {div_rem, div_dvd[DIV_W-1]};
  assign div_ge      = (div_rem_sh >= {1'b0, div_den});
  assign div_rem_sub = div_ge ? (div_rem_sh - {1'b0, div_den}) : div_rem_sh;
  assign div_quot    = {div_dvd[DIV_W-2:0], div_ge};
  assign div_last    = (div_cnt == DIV_CNT_W'(DIV_W - 1));

  // Multiplier operands: speed * reload, or average * 255
  always_comb begin
    if (state == ST_MUL_CMP) begin
      mul_a = speed_wide_mode ? speed_word : {8'd0, speed_byte};
      mul_b = reload_reg;
    end else begin
      mul_a = 16'(DEN_BYTE);
      mul_b = {2'd0, chan0_avg};
    end
  end
  assign mul_p = DIV_W'(mul_a) * DIV_W'(mul_b);

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (accept) begin
          if (is_sample && frame_done) state_next = ST_DIV_AVG;
          else if (is_write)           state_next = ST_RELOAD;
          else                         state_next = ST_FINISH;
        end
      end
      ST_RELOAD: begin
        if (div_last) begin
          if (dir_reg == DIR_FWD || dir_reg == DIR_REV) state_next = ST_MUL_CMP;
          else                                          state_next = ST_FINISH;
        end
      end
      ST_MUL_CMP:  state_next = ST_DIV_CMP;
      ST_DIV_CMP:  if (div_last) state_next = ST_FINISH;
      ST_DIV_AVG:  if (div_last) state_next = ST_MUL_AVG8;
      ST_MUL_AVG8: state_next = ST_DIV_AVG8;
      ST_DIV_AVG8: if (div_last) state_next = ST_FINISH;
      ST_FINISH:   if (load_out) state_next = ST_IDLE;
      default:     state_next = ST_IDLE;
    endcase
  end

  // Control and architectural registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= ST_IDLE;
      out_valid       <= 1'b0;
      addr_offset     <= 4'd0;
      dir_reg         <= DIR_OFF;
      speed_wide_mode <= 1'b0;
      speed_byte      <= 8'd0;
      speed_word      <= 16'd0;
      freq_reg        <= RESET_FREQ;
      reload_reg      <= RESET_RELOAD;
      cmp_fwd         <= 14'd0;
      cmp_rev         <= 14'd0;
      sample_index    <= '0;
      chan_phase      <= '0;
      chan0_sum       <= '0;
      chan0_avg       <= 12'd0;
      chan0_avg8      <= 8'd0;
    end else begin
      state <= state_next;

      if (cfg_we) addr_offset <= cfg_data;

      // output register handshake
      if (load_out)                    out_valid <= 1'b1;
      else if (out_valid && !out_stall) out_valid <= 1'b0;

      // register file update on an accepted word
      if (accept && is_sample) begin
        if (frame_done) begin
          chan0_sum    <= '0;
          sample_index <= '0;
          chan_phase   <= '0;
        end else begin
          chan0_sum    <= sum_add;
          sample_index <= idx_inc;
          chan_phase   <= (chan_phase == CHAN_W'(CHANNELS - 1)) ? '0
                                                                : chan_phase + CHAN_W'(1);
        end
      end
      if (accept && is_write) begin
        if (whit[0]) dir_reg <= wbuf[0];
        if (whit[1]) begin
          speed_wide_mode <= 1'b0;
          speed_byte      <= wbuf[1];
        end
        if (whit[2] && whit[3]) begin
          speed_wide_mode <= 1'b1;
          speed_word      <= {wbuf[3], wbuf[2]};
        end
        freq_reg <= freq_new;
      end

      // divider results
      if (div_last) begin
        case (state)
          ST_RELOAD: begin
            reload_reg <= div_quot[13:0];
            if (dir_reg == DIR_OFF) begin
              cmp_fwd <= 14'd0;
              cmp_rev <= 14'd0;
            end
          end
          ST_DIV_CMP: begin
            if (dir_reg == DIR_FWD) begin
              cmp_fwd <= div_quot[13:0];
              cmp_rev <= 14'd0;
            end else begin
              cmp_fwd <= 14'd0;
              cmp_rev <= div_quot[13:0];
            end
          end
          ST_DIV_AVG:  chan0_avg  <= div_quot[11:0];
          ST_DIV_AVG8: chan0_avg8 <= div_quot[7:0];
          default: ;
        endcase
      end
    end
  end

  // Datapath registers: divider, read response, output word
  always_ff @(posedge clk) begin
    if (accept) begin
      div_rem <= '0;
      div_cnt <= '0;
      if (is_sample) begin
        div_dvd <= DIV_W'(sum_add);
        div_den <= DEN_FRAMES;
      end else begin
        div_dvd <= TICK_RATE;
        div_den <= freq_new;
      end
      if (is_read) begin
        rd_len <= rd_n;
        rd_b0  <= (rd_n != 2'd0) ? rd_val[7:0] : 8'd0;
        rd_b1  <= (rd_n == 2'd2) ? rd_val[15:8] : 8'd0;
      end else begin
        rd_len <= 2'd0;
        rd_b0  <= 8'd0;
        rd_b1  <= 8'd0;
      end
    end else if (state == ST_MUL_CMP || state == ST_MUL_AVG8) begin
      // product goes straight into the divider
      div_dvd <= mul_p;
      div_rem <= '0;
      div_cnt <= '0;
      div_den <= (state == ST_MUL_AVG8) ? DEN_ADC
               : (speed_wide_mode ? DEN_WORD : DEN_BYTE);
    end else if (div_run) begin
      div_dvd <= div_quot;
      div_rem <= div_rem_sub[DEN_W-1:0];
      div_cnt <= div_cnt + DIV_CNT_W'(1);
    end

    if (load_out) begin
      out_word.reload_value <= reload_reg;
      out_word.duty_fwd     <= cmp_fwd;
      out_word.duty_rev     <= cmp_rev;
      out_word.read_len     <= rd_len;
      out_word.read_byte_0  <= rd_b0;
      out_word.read_byte_1  <= rd_b1;
    end
  end

endmodule
